/* rtl/acem_pkg.sv */
package acem_pkg;

  // fixed field widths
  localparam int ADC_BITS  = 10;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 4;
  localparam int CUR_W     = 15;
  localparam int ADD_W     = 22;
  localparam int NRG_W     = 32;

  // stream bus widths, padded to whole bytes
  localparam int IN_W      = 48;
  localparam int OUT_W     = 72;

  localparam int MAX_LOG2_SAMPLES_DEF = 10;
  localparam int LOG2_RESET           = 4;

  // current map: floor(avg*10000/1024) == (avg*625) >> 6
  localparam int ADC_MAX    = 1023;
  localparam int MAP_MUL    = 625;
  localparam int MAP_SHIFT  = 6;
  localparam int MAP_Q_W    = 14;
  localparam int MAP_OFFSET = 5000;

  // derating: floor(s*94/100) == floor(s*47/50)
  localparam int DERATE_MUL = 47;
  localparam int DIVISOR    = 50;

  localparam int ENERGY_SHIFT = 10;

  // shift-add multiplier: one multiplier bit per cycle
  localparam int MUL_W      = 32;
  localparam int MUL_STEPS  = CUR_W;
  localparam int MUL_CNT_W  = 4;

  // restoring divider: one quotient bit per cycle
  localparam int DIV_W      = 20;
  localparam int REM_W      = 7;
  localparam int DIV_CNT_W  = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MAP_GO,
    ST_MAP_WAIT,
    ST_DER_GO,
    ST_DER_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_NRG_GO,
    ST_NRG_WAIT,
    ST_OUT
  } state_t;

endpackage

/* rtl/acem_serial_mul.sv */
module acem_serial_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [acem_pkg::MUL_W-1:0]     a,
  input  logic [acem_pkg::MUL_STEPS-1:0] b,
  output logic                           done,
  output logic [acem_pkg::MUL_W-1:0]     product
);
  import acem_pkg::*;

  logic [MUL_W-1:0]     mcand;
  logic [MUL_STEPS-1:0] mplier;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 running;

  // product wraps modulo 2^MUL_W
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= !start && running && (cnt == MUL_CNT_W'(1));
      if (start) begin
        product <= '0;
        mcand   <= a;
        mplier  <= b;
        cnt     <= MUL_CNT_W'(MUL_STEPS);
        running <= 1'b1;
      end else if (running) begin
        if (mplier[0]) begin
          product <= product + mcand;
        end
        mcand  <= {mcand[MUL_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[MUL_STEPS-1:1]};
        cnt    <= cnt - 1'b1;
        if (cnt == MUL_CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/acem_serial_div.sv */
module acem_serial_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [acem_pkg::DIV_W-1:0] dividend,
  output logic                       done,
  output logic [acem_pkg::DIV_W-1:0] quotient
);
  import acem_pkg::*;

  logic [REM_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic [REM_W:0]       trial;
  logic                 ge;

  // remainder stays below the divisor, so the trial fits one extra bit
  assign trial = {rem, quotient[DIV_W-1]};
  assign ge    = trial >= (REM_W+1)'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= !start && running && (cnt == DIV_CNT_W'(1));
      if (start) begin
        rem      <= '0;
        quotient <= dividend;
        cnt      <= DIV_CNT_W'(DIV_W);
        running  <= 1'b1;
      end else if (running) begin
        if (ge) begin
          rem <= REM_W'(trial - (REM_W+1)'(DIVISOR));
        end else begin
          rem <= trial[REM_W-1:0];
        end
        quotient <= {quotient[DIV_W-2:0], ge};
        cnt      <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/averaged_current_energy_meter.sv */
// Averaged current energy meter.
// s_* stream: one ADC current sample with its millisecond timestamp per
// request. Samples are summed over windows of 2^log2_samples; a sample that
// does not close a window is added to the sum and gives no result.
// The sample that closes a window starts the window sequence: a serial
// right shift for the average, three passes of a shared shift-add
// multiplier (map, derate, energy) with a restoring divide by 50 after the
// derate pass, then the output register is loaded.
// s_tready is low from the closing sample until the result is loaded into
// the output register, so no new sample is taken while a window is processed.
// m_* stream: one result per window from an output register; the next
// samples are still taken while it waits. If the previous result has not
// been taken when a window ends, the block holds until m_tready.
// cfg_* channel: log2_samples write, always ready; write it only when idle.
// Reset (rst, synchronous) clears sums, counters, the energy total and the
// window time, sets log2_samples to 4 and drops m_tvalid.
module averaged_current_energy_meter #(
  parameter int MAX_LOG2_SAMPLES = acem_pkg::MAX_LOG2_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [acem_pkg::IN_W-1:0]  s_tdata,   // sample[9:0], time_ms[41:10]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [acem_pkg::OUT_W-1:0] m_tdata,   // current_scaled[14:0],
                                                // energy_added[36:15],
                                                // energy_total[68:37]
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [acem_pkg::CFG_W-1:0] cfg_data
);
  import acem_pkg::*;

  localparam int SUM_W   = ADC_BITS + MAX_LOG2_SAMPLES;
  localparam int COUNT_W = MAX_LOG2_SAMPLES + 1;
  localparam int OUT_PAD = OUT_W - (CUR_W + ADD_W + NRG_W);

  state_t state, state_next;

  logic [CFG_W-1:0]   log2_samples;
  logic [CFG_W-1:0]   shift_amt;
  logic [SUM_W-1:0]   sample_sum;
  logic [COUNT_W-1:0] sample_count;
  logic [TIME_W-1:0]  last_window_time;
  logic [NRG_W-1:0]   energy_sum;
  logic [SUM_W-1:0]   work;
  logic [CFG_W-1:0]   shift_cnt;
  logic [TIME_W-1:0]  time_hold;
  logic [CUR_W-1:0]   cur;
  logic [ADD_W-1:0]   added;

  logic [CUR_W-1:0]   out_cur;
  logic [ADD_W-1:0]   out_added;
  logic [NRG_W-1:0]   out_energy;

  logic [ADC_BITS-1:0] smp;
  logic [TIME_W-1:0]   now;
  logic [SUM_W-1:0]    sum_new;
  logic [COUNT_W-1:0]  count_new;
  logic                window_end;
  logic                in_fire;
  logic                out_free;
  logic [ADC_BITS-1:0] avg;
  logic [MAP_Q_W-1:0]  map_q;
  logic [MAP_Q_W-1:0]  map_diff;

  logic                mul_start, mul_done;
  logic [MUL_W-1:0]    mul_a, mul_product;
  logic [MUL_STEPS-1:0] mul_b;
  logic                div_start, div_done;
  logic [DIV_W-1:0]    div_quotient;

  assign cfg_ready = 1'b1;

  // window length is capped at the largest supported value
  assign shift_amt = ({1'b0, log2_samples} > (CFG_W+1)'(MAX_LOG2_SAMPLES)) ?
                     CFG_W'(MAX_LOG2_SAMPLES) : log2_samples;

  assign smp        = s_tdata[ADC_BITS-1:0];
  assign now        = s_tdata[ADC_BITS +: TIME_W];
  assign sum_new    = sample_sum + SUM_W'(smp);
  assign count_new  = sample_count + 1'b1;
  assign window_end = count_new >= (COUNT_W'(1) << shift_amt);
  assign in_fire    = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;

  // average saturates if the length was shortened mid-window
  assign avg = (work > SUM_W'(ADC_MAX)) ? ADC_BITS'(ADC_MAX) : work[ADC_BITS-1:0];

  assign map_q    = mul_product[MAP_SHIFT +: MAP_Q_W];
  assign map_diff = map_q - MAP_Q_W'(MAP_OFFSET);

  acem_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  acem_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_product[DIV_W-1:0]),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_fire && window_end) state_next = ST_SHIFT;
      ST_SHIFT:    if (shift_cnt == '0) state_next = ST_MAP_GO;
      ST_MAP_GO:   state_next = ST_MAP_WAIT;
      ST_MAP_WAIT: if (mul_done) state_next = ST_DER_GO;
      ST_DER_GO:   state_next = ST_DER_WAIT;
      ST_DER_WAIT: if (mul_done) state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = ST_NRG_GO;
      ST_NRG_GO:   state_next = ST_NRG_WAIT;
      ST_NRG_WAIT: if (mul_done) state_next = ST_OUT;
      ST_OUT:      if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_MAP_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(MAP_MUL);
        mul_b     = MUL_STEPS'(avg);
      end
      ST_DER_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(cur);
        mul_b     = MUL_STEPS'(DERATE_MUL);
      end
      ST_DIV_GO: div_start = 1'b1;
      ST_NRG_GO: begin
        mul_start = 1'b1;
        mul_a     = time_hold - last_window_time;
        mul_b     = cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      log2_samples     <= CFG_W'(LOG2_RESET);
      sample_sum       <= '0;
      sample_count     <= '0;
      last_window_time <= '0;
      energy_sum       <= '0;
      shift_cnt        <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        log2_samples <= cfg_data;
      end
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (window_end) begin
              work         <= sum_new;
              time_hold    <= now;
              shift_cnt    <= shift_amt;
              sample_sum   <= '0;
              sample_count <= '0;
            end else begin
              sample_sum   <= sum_new;
              sample_count <= count_new;
            end
          end
        end
        ST_SHIFT: begin
          if (shift_cnt != '0) begin
            work      <= work >> 1;
            shift_cnt <= shift_cnt - 1'b1;
          end
        end
        ST_MAP_WAIT: begin
          // non-positive mapped current clamps to zero
          if (mul_done) begin
            cur <= (map_q > MAP_Q_W'(MAP_OFFSET)) ? CUR_W'({map_diff, 2'b00}) : '0;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            cur <= div_quotient[CUR_W-1:0];
          end
        end
        ST_NRG_WAIT: begin
          if (mul_done) begin
            added <= mul_product[ENERGY_SHIFT +: ADD_W];
          end
        end
        ST_OUT: begin
          if (out_free) begin
            energy_sum       <= energy_sum + NRG_W'(added);
            last_window_time <= time_hold;
            out_cur          <= cur;
            out_added        <= added;
            out_energy       <= energy_sum + NRG_W'(added);
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {{OUT_PAD{1'b0}}, out_energy, out_added, out_cur};

endmodule
